/* rtl/core/gmg_pkg.sv */
// ----------------------------------------------------------------------------
// gmg_pkg
// Types and constants shared by the month grid pipeline, its row emitter
// and its checker.
// ----------------------------------------------------------------------------
package gmg_pkg;

   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int WDAY_W     = 3;
   localparam int DAY_W      = 5;
   localparam int ROW_W      = 3;
   localparam int TABLE_W    = 36;
   localparam int CSR_DATA_W = 36;
   localparam int CSR_IDX_W  = 1;
   localparam int SUM_W      = 16;
   localparam int GRID_COLS  = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF_YEAR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_TABLE = 1'b1;

   localparam logic [YEAR_W-1:0]  REF_YEAR_RESET  = 14'd2024;
   localparam logic [TABLE_W-1:0] REF_TABLE_RESET = 36'd65892987745;

   // month codes
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;
   localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;

   localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
   localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
   localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;
   localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;

   localparam logic [ROW_W-1:0] LAST_ROW = 3'd5;

   // floor(x / 25) for x < 4096 as (x * 5243) >> 17
   localparam logic [12:0] DIV25_MUL = 13'd5243;

   // multiple of 7 that keeps the weekday sum positive
   localparam logic [SUM_W-1:0] MOD7_BIAS = 16'd28672;

   typedef struct packed {
      logic [YEAR_W-1:0]  query_year;
      logic [MONTH_W-1:0] query_month;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [DAY_W-1:0] day_monday;
      logic [DAY_W-1:0] day_tuesday;
      logic [DAY_W-1:0] day_wednesday;
      logic [DAY_W-1:0] day_thursday;
      logic [DAY_W-1:0] day_friday;
      logic [DAY_W-1:0] day_saturday;
      logic [DAY_W-1:0] day_sunday;
      logic             last_row;
   } rsp_type;

   typedef struct packed {
      logic [WDAY_W-1:0] col0;
      logic [DAY_W-1:0]  len;
   } grid_spec_type;

   function automatic logic [7:0] div25(input logic [11:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'(DIV25_MUL);
      return p[24:17];
   endfunction

   // octal digits sum to the same residue, since 8 is 1 mod 7
   function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] x);
      logic [17:0] xe;
      logic [5:0]  s;
      logic [3:0]  t;
      xe = {2'b00, x};
      s  = '0;
      for (int i = 0; i < 6; i++) begin
         s = s + 6'(xe[3*i +: 3]);
      end
      t = 4'(s[2:0]) + 4'(s[5:3]);
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[2:0];
   endfunction

endpackage

/* rtl/core/gregorian_month_grid.sv */
// ----------------------------------------------------------------------------
// gregorian_month_grid
// Monday-first calendar grid of one month, six week rows per query.
// ----------------------------------------------------------------------------
// Each accepted query (year, month) yields six output transfers, rows 0 to 5,
// the last flagged by last_row. The weekday of the 1st is computed in a
// four-stage pipeline (select and offsets, divide-by-25 multipliers, leap
// counts and month length, mod-7 reduction), and the rows go out through the
// row emitter's output register. The emitter sends one row per cycle while the
// output is ready, and takes the next grid as it sends the last row. Months 12 to
// 15 give six rows of empty cells. Write the reference year and its table of
// first weekdays through the csr port only while no query is in flight.
module gregorian_month_grid (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gmg_pkg::req_type                req,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gmg_pkg::rsp_type                rsp,
   input  logic                            csr_write_enable,
   input  logic [gmg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gmg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gmg_pkg::*;

   logic [YEAR_W-1:0]  ref_year_ff;
   logic [TABLE_W-1:0] ref_table_ff;

   // stage A
   logic                a_v_ff;
   logic [YEAR_W-1:0]   a_year_ff;
   logic [MONTH_W-1:0]  a_mon_ff;
   logic                a_ok_ff;
   logic [WDAY_W-1:0]   a_w0_ff;
   logic [SUM_W-1:0]    a_diff_ff;
   logic [YEAR_W-1:0]   a_my_ff;
   logic                a_zy_ff;
   logic [YEAR_W-1:0]   a_mr_ff;
   logic                a_zr_ff;
   logic                a_ok_in;
   logic [WDAY_W-1:0]   a_w0_in;
   logic [SUM_W-1:0]    a_diff_in;
   logic [YEAR_W:0]     ny;
   logic [YEAR_W:0]     nr;
   logic [YEAR_W:0]     a_my_in;
   logic [YEAR_W:0]     a_mr_in;
   logic [5:0]          tbl_idx;
   logic [TABLE_W-1:0]  tbl_shift;

   // stage B
   logic                b_v_ff;
   logic [YEAR_W-1:0]   b_year_ff;
   logic [MONTH_W-1:0]  b_mon_ff;
   logic                b_ok_ff;
   logic [WDAY_W-1:0]   b_w0_ff;
   logic [SUM_W-1:0]    b_diff_ff;
   logic [11:0]         b_m4y_ff;
   logic                b_zy_ff;
   logic [11:0]         b_m4r_ff;
   logic                b_zr_ff;
   logic [7:0]          b_q100y_ff;
   logic [5:0]          b_q400y_ff;
   logic [7:0]          b_q100r_ff;
   logic [5:0]          b_q400r_ff;
   logic [7:0]          b_qa_ff;
   logic [5:0]          b_qb_ff;
   logic [7:0]          b_q100y_in;
   logic [7:0]          b_q400y_in;
   logic [7:0]          b_q100r_in;
   logic [7:0]          b_q400r_in;
   logic [7:0]          b_qa_in;
   logic [7:0]          b_qb_in;

   // stage C
   logic                c_v_ff;
   logic [SUM_W-1:0]    c_total_ff;
   logic [DAY_W-1:0]    c_len_ff;
   logic [SUM_W-1:0]    c_total_in;
   logic [DAY_W-1:0]    c_len_in;
   logic [SUM_W-1:0]    ly;
   logic [SUM_W-1:0]    lr;
   logic [12:0]         qa25;
   logic [9:0]          qb25;
   logic                cent;
   logic                quad;
   logic                leap;

   // stage D
   logic                d_v_ff;
   grid_spec_type       d_spec_ff;
   grid_spec_type       d_spec_in;
   logic [WDAY_W-1:0]   wday;

   logic                a_rdy;
   logic                b_rdy;
   logic                c_rdy;
   logic                d_rdy;
   logic                spec_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_year_ff  <= REF_YEAR_RESET;
         ref_table_ff <= REF_TABLE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_REF_YEAR) begin
            ref_year_ff <= csr_wdata[YEAR_W-1:0];
         end else if (csr_index == CSR_REF_TABLE) begin
            ref_table_ff <= csr_wdata[TABLE_W-1:0];
         end
      end
   end

   assign d_rdy     = !d_v_ff || spec_ready;
   assign c_rdy     = !c_v_ff || d_rdy;
   assign b_rdy     = !b_v_ff || c_rdy;
   assign a_rdy     = !a_v_ff || b_rdy;
   assign req_ready = a_rdy;

   // stage A: table entry, leap-count arguments, year offset
   always_comb begin
      a_ok_in   = req.query_month < MONTHS;
      tbl_idx   = 6'(req.query_month) * 6'd3;
      tbl_shift = ref_table_ff >> tbl_idx;
      a_w0_in   = a_ok_in ? tbl_shift[WDAY_W-1:0] : '0;
      if (req.query_month < MONTH_MAR) begin
         ny = {1'b0, req.query_year};
         nr = {1'b0, ref_year_ff};
      end else begin
         ny = {1'b0, req.query_year} + 15'd1;
         nr = {1'b0, ref_year_ff} + 15'd1;
      end
      a_my_in   = ny - 15'd1;
      a_mr_in   = nr - 15'd1;
      a_diff_in = SUM_W'(req.query_year) - SUM_W'(ref_year_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_rdy) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && a_rdy) begin
         a_year_ff <= req.query_year;
         a_mon_ff  <= req.query_month;
         a_ok_ff   <= a_ok_in;
         a_w0_ff   <= a_w0_in;
         a_diff_ff <= a_diff_in;
         a_my_ff   <= a_my_in[YEAR_W-1:0];
         a_zy_ff   <= ny == '0;
         a_mr_ff   <= a_mr_in[YEAR_W-1:0];
         a_zr_ff   <= nr == '0;
      end
   end

   // stage B: quotients by 100 and 400 through divide-by-25 multipliers
   always_comb begin
      b_q100y_in = div25(a_my_ff[13:2]);
      b_q400y_in = div25({2'b00, a_my_ff[13:4]});
      b_q100r_in = div25(a_mr_ff[13:2]);
      b_q400r_in = div25({2'b00, a_mr_ff[13:4]});
      b_qa_in    = div25(a_year_ff[13:2]);
      b_qb_in    = div25({2'b00, a_year_ff[13:4]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_rdy) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_v_ff && b_rdy) begin
         b_year_ff  <= a_year_ff;
         b_mon_ff   <= a_mon_ff;
         b_ok_ff    <= a_ok_ff;
         b_w0_ff    <= a_w0_ff;
         b_diff_ff  <= a_diff_ff;
         b_m4y_ff   <= a_my_ff[13:2];
         b_zy_ff    <= a_zy_ff;
         b_m4r_ff   <= a_mr_ff[13:2];
         b_zr_ff    <= a_zr_ff;
         b_q100y_ff <= b_q100y_in;
         b_q400y_ff <= b_q400y_in[5:0];
         b_q100r_ff <= b_q100r_in;
         b_q400r_ff <= b_q400r_in[5:0];
         b_qa_ff    <= b_qa_in;
         b_qb_ff    <= b_qb_in[5:0];
      end
   end

   // stage C: leap counts, weekday sum, month length
   always_comb begin
      ly = b_zy_ff ? '0 :
           SUM_W'(b_m4y_ff) - SUM_W'(b_q100y_ff) + SUM_W'(b_q400y_ff) + 16'd1;
      lr = b_zr_ff ? '0 :
           SUM_W'(b_m4r_ff) - SUM_W'(b_q100r_ff) + SUM_W'(b_q400r_ff) + 16'd1;
      c_total_in = MOD7_BIAS + SUM_W'(b_w0_ff) + b_diff_ff + ly - lr;
      qa25 = 13'(b_qa_ff) * 13'd25;
      qb25 = 10'(b_qb_ff) * 10'd25;
      cent = qa25 == {1'b0, b_year_ff[13:2]};
      quad = qb25 == b_year_ff[13:4];
      leap = (b_year_ff[1:0] == 2'b00) && (!cent || (b_year_ff[3:2] == 2'b00 && quad));
      c_len_in = '0;
      if (b_ok_ff) begin
         unique case (b_mon_ff)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: c_len_in = LEN_SHORT;
            MONTH_FEB: c_len_in = leap ? LEN_LEAP : LEN_FEB;
            default: c_len_in = LEN_LONG;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (c_rdy) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_v_ff && c_rdy) begin
         c_total_ff <= c_total_in;
         c_len_ff   <= c_len_in;
      end
   end

   // stage D: weekday of the 1st, then its Monday-first column
   always_comb begin
      wday           = mod7(c_total_ff);
      d_spec_in.col0 = (wday == '0) ? 3'd6 : wday - 3'd1;
      d_spec_in.len  = c_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (d_rdy) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_v_ff && d_rdy) begin
         d_spec_ff <= d_spec_in;
      end
   end

   gmg_row_emit u_row_emit (
      .clock      (clock),
      .reset      (reset),
      .spec_valid (d_v_ff),
      .spec_ready (spec_ready),
      .spec       (d_spec_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule

/* rtl/core/gmg_row_emit.sv */
// ----------------------------------------------------------------------------
// gmg_row_emit
// Expands one grid description into six week rows, one row per output
// transfer, through a registered output stage.
// ----------------------------------------------------------------------------
module gmg_row_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  spec_valid,
   output logic                  spec_ready,
   input  gmg_pkg::grid_spec_type spec,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gmg_pkg::rsp_type      rsp
);
   import gmg_pkg::*;

   grid_spec_type           spec_ff;
   logic                    busy_ff;
   logic [ROW_W-1:0]        row_ff;
   logic                    out_v_ff;
   rsp_type                 out_ff;
   rsp_type                 out_in;
   logic [DAY_W-1:0]        days [GRID_COLS];
   logic [5:0]              raw;
   logic [5:0]              day;
   logic                    out_free;
   logic                    emit;
   logic                    final_row;

   assign out_free   = !out_v_ff || rsp_ready;
   assign emit       = busy_ff && out_free;
   assign final_row  = row_ff == LAST_ROW;
   assign spec_ready = !busy_ff || (emit && final_row);

   always_comb begin
      raw = '0;
      day = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         raw = 6'(row_ff) * 6'd7 + 6'(c) + 6'd1;
         day = raw - 6'(spec_ff.col0);
         if (raw > 6'(spec_ff.col0) && day <= 6'(spec_ff.len)) begin
            days[c] = day[DAY_W-1:0];
         end else begin
            days[c] = '0;
         end
      end
      out_in.row_index     = row_ff;
      out_in.day_monday    = days[0];
      out_in.day_tuesday   = days[1];
      out_in.day_wednesday = days[2];
      out_in.day_thursday  = days[3];
      out_in.day_friday    = days[4];
      out_in.day_saturday  = days[5];
      out_in.day_sunday    = days[6];
      out_in.last_row      = final_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         row_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (spec_valid && spec_ready) begin
            busy_ff <= 1'b1;
            row_ff  <= '0;
         end else if (emit) begin
            if (final_row) begin
               busy_ff <= 1'b0;
            end
            row_ff <= row_ff + 3'd1;
         end
         if (emit) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (spec_valid && spec_ready) begin
         spec_ff <= spec;
      end
      if (emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

endmodule

/* rtl/core/gmg_checker.sv */
// ----------------------------------------------------------------------------
// gmg_checker
// Port-level checks of the month grid output stream.
// ----------------------------------------------------------------------------
module gmg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input gmg_pkg::req_type                req,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input gmg_pkg::rsp_type                rsp,
   input logic                            csr_write_enable,
   input logic [gmg_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [gmg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gmg_pkg::*;

   logic unused_inputs;
   assign unused_inputs = req_valid ^ req_ready ^ (^req) ^ csr_write_enable ^
                          (^csr_index) ^ (^csr_wdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp dropped or changed before transfer");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.last_row == (rsp.row_index == LAST_ROW)))
      else $error("last_row does not match row_index");

   a_next_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp.last_row |=>
         !rsp_valid || rsp.row_index == $past(rsp.row_index) + 3'd1)
      else $error("rows out of order");

   a_consecutive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.day_monday != '0 && rsp.day_tuesday != '0 |->
         rsp.day_tuesday == rsp.day_monday + 5'd1)
      else $error("adjacent days not consecutive");

endmodule

bind gregorian_month_grid gmg_checker u_gmg_checker (.*);
